/* sv/lru_key_value_cache_macros.svh */
// Assertion macros used by the checker of the LRU key-value cache.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru cache check failed");

// Delayed check: the consequent must hold after the antecedent, not in the same cycle.
`define LKV_ASSERT_TWO(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("lru cache check failed");

`endif

/* sv/lkv_pkg.sv */
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  // Word index of the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_SET = 1'b1
  } kind_t;

  typedef struct packed {
    logic               kind;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic               touch;
    logic               fill;
    logic               write_key;
    logic               write_value;
    logic [ENTRIES-1:0] targ_oh;
    logic [CNT_W-1:0]   old_age;
    logic               hit;
    logic [VAL_W-1:0]   read_value;
  } decision_t;

endpackage

/* sv/lru_key_value_cache.sv */
// A get passes through the input register and the result register, which shows
// its result for one cycle; sets give no result.
// Throughput: one item per cycle, busy is always low. The whole lookup, victim
// choice and recency update are combinational on the input register, against sixteen parallel comparators.
// Reset (synchronous, rst_n low): all entries invalid, use count zero, capacity 16.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_key_value_cache (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lkv_pkg::in_item_t           in_item,
  output logic                        out_valid,
  output lkv_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0]  paddr,
  input  logic [lkv_pkg::DATA_W-1:0]  pwdata,
  output logic [lkv_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // The pipeline has two register stages: the input register and the result
  // register. The cache state itself is updated at the same edge that loads the
  // result register, so the next item, loaded into the input register at that edge, always sees the state
  // left by this one. No forwarding is needed and nothing ever stalls.
  logic                        req_vld_r;
  logic                        req_vld_nxt;
  lkv_pkg::in_item_t           req_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  lkv_pkg::out_item_t          out_item_r;
  lkv_pkg::out_item_t          out_item_nxt;

  logic [lkv_pkg::CNT_W-1:0]   cap_eff;
  logic [lkv_pkg::ENTRIES-1:0] valid;
  logic [lkv_pkg::KEY_W-1:0]   keys   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::VAL_W-1:0]   values [lkv_pkg::ENTRIES];
  logic [lkv_pkg::AGE_W-1:0]   ages   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::CNT_W-1:0]   used;
  lkv_pkg::decision_t          dec;

  // Every cycle can take an item.
  assign busy = 1'b0;

  // Capacity register and its APB access.
  lkv_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_cap_eff (cap_eff)
  );

  assign req_vld_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_nxt) begin
      req_r <= in_item;
    end
  end

  // Key compare, free slot and victim search, and the recency decision.
  // The least recent entry is the one whose rank equals the use count less one,
  // because the valid entries always hold each rank once.
  lkv_lookup u_lookup (
    .req_vld (req_vld_r),
    .req     (req_r),
    .valid   (valid),
    .keys    (keys),
    .values  (values),
    .ages    (ages),
    .used    (used),
    .cap     (cap_eff),
    .dec     (dec)
  );

  // Entry storage: keys, values and ranks are plain registers, one per slot;
  // only the valid bits and the use count are cleared by reset.
  lkv_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .dec      (dec),
    .wr_key   (req_r.key),
    .wr_value (req_r.value),
    .valid    (valid),
    .keys     (keys),
    .values   (values),
    .ages     (ages),
    .used     (used)
  );

  // Only a get gives a result item. A miss reads back all ones.
  assign out_valid_nxt           = req_vld_r && (req_r.kind == lkv_pkg::KIND_GET);
  assign out_item_nxt.hit        = dec.hit;
  assign out_item_nxt.read_value = dec.read_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/lkv_cfg.sv */
module lkv_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0]        paddr,
  input  logic [lkv_pkg::DATA_W-1:0]        pwdata,
  output logic [lkv_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  output logic [lkv_pkg::CNT_W-1:0]         cfg_cap_eff
);

  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic [lkv_pkg::CAP_W-1:0] cap_nxt;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == lkv_pkg::REG_CAPACITY);

  always_comb begin
    cap_nxt = cap_r;
    if (wr_en) begin
      cap_nxt = pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAPACITY_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lkv_pkg::REG_CAPACITY) begin
      prdata = lkv_pkg::DATA_W'(cap_r);
    end
  end

  // A capacity above the entry count behaves as the entry count.
  assign cfg_cap_eff = (32'(cap_r) > lkv_pkg::ENTRIES) ? lkv_pkg::CNT_W'(lkv_pkg::ENTRIES)
                                                      : lkv_pkg::CNT_W'(cap_r);

endmodule

/* sv/lkv_lookup.sv */
module lkv_lookup (
  input  logic                               req_vld,
  input  lkv_pkg::in_item_t                  req,
  input  logic [lkv_pkg::ENTRIES-1:0]        valid,
  input  logic [lkv_pkg::KEY_W-1:0]          keys   [lkv_pkg::ENTRIES],
  input  logic [lkv_pkg::VAL_W-1:0]          values [lkv_pkg::ENTRIES],
  input  logic [lkv_pkg::AGE_W-1:0]          ages   [lkv_pkg::ENTRIES],
  input  logic [lkv_pkg::CNT_W-1:0]          used,
  input  logic [lkv_pkg::CNT_W-1:0]          cap,
  output lkv_pkg::decision_t                 dec
);

  logic [lkv_pkg::ENTRIES-1:0] match;
  logic [lkv_pkg::ENTRIES-1:0] free_oh;
  logic [lkv_pkg::ENTRIES-1:0] victim_oh;
  logic [lkv_pkg::AGE_W-1:0]   match_age;
  logic [lkv_pkg::VAL_W-1:0]   match_value;
  logic [lkv_pkg::CNT_W-1:0]   oldest;
  logic                        hit;
  logic                        is_set;
  logic                        room;
  logic                        fill;
  logic                        evict;

  assign oldest = used - lkv_pkg::CNT_W'(1);

  always_comb begin
    match_age   = '0;
    match_value = '0;
    for (int j = 0; j < lkv_pkg::ENTRIES; j++) begin
      match[j]     = valid[j] && (keys[j] == req.key);
      victim_oh[j] = valid[j] && (lkv_pkg::CNT_W'(ages[j]) == oldest);
      match_age    = match_age | (ages[j] & {lkv_pkg::AGE_W{match[j]}});
      match_value  = match_value | (values[j] & {lkv_pkg::VAL_W{match[j]}});
    end
  end

  // Lowest free slot: the lowest zero bit of the valid vector.
  assign free_oh = ~valid & (valid + lkv_pkg::ENTRIES'(1));

  assign hit    = |match;
  assign is_set = (req.kind == lkv_pkg::KIND_SET);
  assign room   = (used < cap);
  assign fill   = is_set && !hit && (cap != '0) && room;
  assign evict  = is_set && !hit && (cap != '0) && !room;

  always_comb begin
    dec             = '0;
    dec.hit         = hit;
    dec.read_value  = hit ? match_value : '1;
    dec.touch       = req_vld && (hit || fill || evict);
    dec.fill        = req_vld && fill;
    dec.write_key   = req_vld && (fill || evict);
    dec.write_value = req_vld && is_set && (hit || fill || evict);
    if (hit) begin
      dec.targ_oh = match;
      dec.old_age = lkv_pkg::CNT_W'(match_age);
    end else if (fill) begin
      dec.targ_oh = free_oh;
      dec.old_age = used;
    end else begin
      dec.targ_oh = victim_oh;
      dec.old_age = oldest;
    end
  end

endmodule

/* sv/lkv_store.sv */
module lkv_store (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lkv_pkg::decision_t                 dec,
  input  logic [lkv_pkg::KEY_W-1:0]          wr_key,
  input  logic [lkv_pkg::VAL_W-1:0]          wr_value,
  output logic [lkv_pkg::ENTRIES-1:0]        valid,
  output logic [lkv_pkg::KEY_W-1:0]          keys   [lkv_pkg::ENTRIES],
  output logic [lkv_pkg::VAL_W-1:0]          values [lkv_pkg::ENTRIES],
  output logic [lkv_pkg::AGE_W-1:0]          ages   [lkv_pkg::ENTRIES],
  output logic [lkv_pkg::CNT_W-1:0]          used
);

  logic [lkv_pkg::ENTRIES-1:0] valid_r;
  logic [lkv_pkg::ENTRIES-1:0] valid_nxt;
  logic [lkv_pkg::CNT_W-1:0]   used_r;
  logic [lkv_pkg::CNT_W-1:0]   used_nxt;
  logic [lkv_pkg::KEY_W-1:0]   key_r   [lkv_pkg::ENTRIES];
  logic [lkv_pkg::VAL_W-1:0]   value_r [lkv_pkg::ENTRIES];
  logic [lkv_pkg::AGE_W-1:0]   age_r   [lkv_pkg::ENTRIES];

  assign valid_nxt = dec.fill ? (valid_r | dec.targ_oh) : valid_r;
  assign used_nxt  = dec.fill ? (used_r + lkv_pkg::CNT_W'(1)) : used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
    end
  end

  // The touched slot becomes rank zero; every valid slot that was more recent
  // than it moves back by one rank.
  always_ff @(posedge clk) begin
    for (int j = 0; j < lkv_pkg::ENTRIES; j++) begin
      if (dec.touch) begin
        if (dec.targ_oh[j]) begin
          age_r[j] <= '0;
        end else if (valid_r[j] && (lkv_pkg::CNT_W'(age_r[j]) < dec.old_age)) begin
          age_r[j] <= age_r[j] + lkv_pkg::AGE_W'(1);
        end
      end
      if (dec.write_key && dec.targ_oh[j]) begin
        key_r[j] <= wr_key;
      end
      if (dec.write_value && dec.targ_oh[j]) begin
        value_r[j] <= wr_value;
      end
    end
  end

  assign valid  = valid_r;
  assign keys   = key_r;
  assign values = value_r;
  assign ages   = age_r;
  assign used   = used_r;

endmodule

/* sv/lkv_checker.sv */
`include "lru_key_value_cache_macros.svh"

module lkv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input lkv_pkg::in_item_t  in_item,
  input logic               out_valid,
  input lkv_pkg::out_item_t out_item,
  input logic               pready
);

  logic get_acc;
  logic set_acc;

  assign get_acc = start && !busy && (in_item.kind == lkv_pkg::KIND_GET);
  assign set_acc = start && !busy && (in_item.kind == lkv_pkg::KIND_SET);

  // Every accepted get is followed by a result once it has passed the input and result registers.
  `LKV_ASSERT_TWO(a_get_result, get_acc, out_valid)
  // A set never produces a result.
  `LKV_ASSERT_TWO(a_set_silent, set_acc, !out_valid)
  // A miss always reads back all ones.
  `LKV_ASSERT_NOW(a_miss_value, out_valid && !out_item.hit, out_item.read_value == '1)
  // The block never holds off items or register accesses.
  `LKV_ASSERT_NOW(a_no_stall, 1'b1, !busy && pready)

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
